@@ design/gain_scheduled_pd_steering_core_assert.svh @@
// ----------------------------------------------------------------------------
// gain scheduled pd steering assertion macros
// shared property forms, sampled on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef GAIN_SCHEDULED_PD_STEERING_CORE_ASSERT_SVH
`define GAIN_SCHEDULED_PD_STEERING_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define GSPD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define GSPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/gspd_pkg.sv @@
// ----------------------------------------------------------------------------
// gspd_pkg
// types and fixed widths shared by the pd steering pipeline
// ----------------------------------------------------------------------------
package gspd_pkg;

   localparam int ANGLE_W  = 16;
   localparam int ERR_W    = 17;
   localparam int DIFF_W   = 18;
   localparam int GAIN_W   = 24;
   localparam int LIM_W    = 13;
   localparam int OFF_W    = 16;
   localparam int DUTY_W   = 14;
   localparam int AREA_W   = 3;
   localparam int CNT_W    = 8;
   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_D_W = GAIN_W + DIFF_W;
   localparam int ACC_W    = PROD_D_W + 1;
   localparam int FRAC_W   = 12;
   localparam int QUOT_W   = ACC_W - FRAC_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = GAIN_W;

   // track area codes
   localparam logic [AREA_W-1:0] AREA_STRAIGHT    = 3'd0;
   localparam logic [AREA_W-1:0] AREA_ROUND       = 3'd1;
   localparam logic [AREA_W-1:0] AREA_ROUND_ENTRY = 3'd2;
   localparam logic [AREA_W-1:0] AREA_ROUND_EXIT  = 3'd3;

   // register reset values
   localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P_STRAIGHT   = 3'd0,
      CSR_GAIN_D_STRAIGHT   = 3'd1,
      CSR_GAIN_P_ROUND      = 3'd2,
      CSR_GAIN_D_ROUND      = 3'd3,
      CSR_GAIN_P_TRANSITION = 3'd4,
      CSR_GAIN_D_TRANSITION = 3'd5,
      CSR_START_LIMIT       = 3'd6,
      CSR_STRAIGHT_LIMIT    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p_straight;
      logic signed [GAIN_W-1:0] gain_d_straight;
      logic signed [GAIN_W-1:0] gain_p_round;
      logic signed [GAIN_W-1:0] gain_d_round;
      logic signed [GAIN_W-1:0] gain_p_transition;
      logic signed [GAIN_W-1:0] gain_d_transition;
      logic [LIM_W-1:0]         start_limit;
      logic [LIM_W-1:0]         straight_limit;
   } cfg_type;

   // word after the input stage
   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [DIFF_W-1:0] diff;
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] kd;
      logic                     update;
      logic                     lim_en;
      logic [LIM_W-1:0]         lim;
   } stage_a_type;

   // word after the multiplier stage
   typedef struct packed {
      logic signed [PROD_P_W-1:0] prod_p;
      logic signed [PROD_D_W-1:0] prod_d;
      logic                       update;
      logic                       lim_en;
      logic [LIM_W-1:0]           lim;
   } stage_b_type;

endpackage

@@ design/gspd_if.sv @@
// ----------------------------------------------------------------------------
// gspd channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface gspd_req_if;
   import gspd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] heading_sum;
   logic signed [ANGLE_W-1:0] target_error;
   logic [AREA_W-1:0]         area_code;
   logic                      nav_active;
   logic [CNT_W-1:0]          laps_done;
   logic [CNT_W-1:0]          sections_passed;

   modport source (
      output valid, heading_sum, target_error, area_code, nav_active,
             laps_done, sections_passed,
      input  ready
   );
   modport sink (
      input  valid, heading_sum, target_error, area_code, nav_active,
             laps_done, sections_passed,
      output ready
   );
endinterface

interface gspd_rsp_if;
   import gspd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       servo_duty;
   logic signed [OFF_W-1:0] pd_offset;

   modport source (
      output valid, servo_duty, pd_offset,
      input  ready
   );
   modport sink (
      input  valid, servo_duty, pd_offset,
      output ready
   );
endinterface

@@ design/gspd_front.sv @@
// ----------------------------------------------------------------------------
// gspd_front
// input stage: heading error, error change, gain and limit selection
// ----------------------------------------------------------------------------
module gspd_front #(
   parameter int START_SECTIONS = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   gspd_req_if.sink                 req_ch,
   input  gspd_pkg::cfg_type        cfg,
   output gspd_pkg::stage_a_type    a_word,
   output logic                     a_valid,
   input  logic                     a_ready
);
   import gspd_pkg::*;

   localparam logic [CNT_W-1:0] START_SEC_C = CNT_W'(START_SECTIONS);

   logic                    accept;
   logic signed [ERR_W-1:0] err;
   logic signed [ERR_W-1:0] prev_ff;
   logic                    a_vld_ff;
   stage_a_type             a_ff;
   stage_a_type             a_in;
   logic                    known;
   logic                    start_phase;

   assign req_ch.ready = !a_vld_ff || a_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // heading error and its change since the last word
   assign err = {req_ch.heading_sum[ANGLE_W-1], req_ch.heading_sum}
              - {req_ch.target_error[ANGLE_W-1], req_ch.target_error};

   // offset limit: start phase wins over the area limit
   assign start_phase = (req_ch.laps_done == '0) && (req_ch.sections_passed <= START_SEC_C);

   // gain pair by area, error terms and limit selection
   always_comb begin
      known = 1'b1;
      a_in.kp = '0;
      a_in.kd = '0;
      case (req_ch.area_code)
         AREA_STRAIGHT: begin
            a_in.kp = cfg.gain_p_straight;
            a_in.kd = cfg.gain_d_straight;
         end
         AREA_ROUND: begin
            a_in.kp = cfg.gain_p_round;
            a_in.kd = cfg.gain_d_round;
         end
         AREA_ROUND_ENTRY, AREA_ROUND_EXIT: begin
            a_in.kp = cfg.gain_p_transition;
            a_in.kd = cfg.gain_d_transition;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      a_in.err    = err;
      a_in.diff   = {err[ERR_W-1], err} - {prev_ff[ERR_W-1], prev_ff};
      a_in.update = req_ch.nav_active && known;
      a_in.lim_en = start_phase || (req_ch.area_code == AREA_STRAIGHT)
                    || (req_ch.area_code == AREA_ROUND_EXIT);
      a_in.lim    = start_phase ? cfg.start_limit : cfg.straight_limit;
   end

   // stage valid and error history
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         if (req_ch.ready) a_vld_ff <= req_ch.valid;
         if (accept) prev_ff <= err;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept) a_ff <= a_in;
   end

   assign a_word  = a_ff;
   assign a_valid = a_vld_ff;

`include "gain_scheduled_pd_steering_core_assert.svh"

   `GSPD_ASSERT_NEXT(a_prev_hold, !accept, $stable(prev_ff), "error history moved without a word")
   `GSPD_ASSERT_NEXT(a_fill, accept, a_vld_ff, "accepted word missing from input stage")
   `GSPD_ASSERT_NEXT(a_keep, a_vld_ff && !a_ready, a_vld_ff && $stable(a_ff),
                     "stalled input stage lost its word")

endmodule

@@ design/gspd_mult.sv @@
// ----------------------------------------------------------------------------
// gspd_mult
// multiplier stage: p and d products of the selected gain pair
// ----------------------------------------------------------------------------
module gspd_mult (
   input  logic                     clock,
   input  logic                     reset,
   input  gspd_pkg::stage_a_type    a_word,
   input  logic                     a_valid,
   output logic                     a_ready,
   output gspd_pkg::stage_b_type    b_word,
   output logic                     b_valid,
   input  logic                     b_ready
);
   import gspd_pkg::*;

   logic        b_vld_ff;
   stage_b_type b_ff;
   stage_b_type b_in;

   assign a_ready = !b_vld_ff || b_ready;

   // two independent products
   assign b_in.prod_p = $signed(a_word.kp) * $signed(a_word.err);
   assign b_in.prod_d = $signed(a_word.kd) * $signed(a_word.diff);
   assign b_in.update = a_word.update;
   assign b_in.lim_en = a_word.lim_en;
   assign b_in.lim    = a_word.lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (a_ready) begin
         b_vld_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid && a_ready) b_ff <= b_in;
   end

   assign b_word  = b_ff;
   assign b_valid = b_vld_ff;

endmodule

@@ design/gspd_back.sv @@
// ----------------------------------------------------------------------------
// gspd_back
// output stage: q12 scaling, saturation, held offset, limits, servo clamp
// ----------------------------------------------------------------------------
module gspd_back #(
   parameter int SERVO_MIN = 500,
   parameter int SERVO_MID = 750,
   parameter int SERVO_MAX = 1000
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gspd_pkg::stage_b_type    b_word,
   input  logic                     b_valid,
   output logic                     b_ready,
   gspd_rsp_if.source               rsp_ch
);
   import gspd_pkg::*;

   localparam logic signed [DIFF_W-1:0] MIN_C = DIFF_W'(SERVO_MIN);
   localparam logic signed [DIFF_W-1:0] MID_C = DIFF_W'(SERVO_MID);
   localparam logic signed [DIFF_W-1:0] MAX_C = DIFF_W'(SERVO_MAX);
   localparam logic [DUTY_W-1:0] MIN_D = DUTY_W'(SERVO_MIN);
   localparam logic [DUTY_W-1:0] MAX_D = DUTY_W'(SERVO_MAX);

   logic                     fire;
   logic signed [ACC_W-1:0]  acc;
   logic signed [QUOT_W-1:0] quot;
   logic signed [OFF_W-1:0]  pd_sat;
   logic signed [OFF_W-1:0]  held_in;
   logic signed [OFF_W-1:0]  held_ff;
   logic signed [ERR_W-1:0]  off_ext;
   logic signed [ERR_W-1:0]  lim_pos;
   logic signed [ERR_W-1:0]  lim_neg;
   logic signed [ERR_W-1:0]  off_lim;
   logic signed [DIFF_W-1:0] duty_raw;
   logic signed [DIFF_W-1:0] duty_clip;
   logic                     out_vld_ff;
   logic [DUTY_W-1:0]        duty_ff;
   logic signed [OFF_W-1:0]  offset_ff;

   assign b_ready = !out_vld_ff || rsp_ch.ready;
   assign fire    = b_valid && b_ready;

   // pd sum, divide by 4096 toward zero
   assign acc = {{(ACC_W-PROD_P_W){b_word.prod_p[PROD_P_W-1]}}, b_word.prod_p}
              + {b_word.prod_d[PROD_D_W-1], b_word.prod_d};
   assign quot = acc[ACC_W-1:FRAC_W]
               + QUOT_W'(acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0));

   // saturate to 16 bits
   always_comb begin
      if (quot[QUOT_W-1:OFF_W-1] == '0 || quot[QUOT_W-1:OFF_W-1] == '1) begin
         pd_sat = quot[OFF_W-1:0];
      end else if (quot[QUOT_W-1]) begin
         pd_sat = {1'b1, {(OFF_W-1){1'b0}}};
      end else begin
         pd_sat = {1'b0, {(OFF_W-1){1'b1}}};
      end
   end

   assign held_in = b_word.update ? pd_sat : held_ff;

   // symmetric offset limit
   assign off_ext = {held_in[OFF_W-1], held_in};
   assign lim_pos = {{(ERR_W-LIM_W){1'b0}}, b_word.lim};
   assign lim_neg = -lim_pos;

   always_comb begin
      off_lim = off_ext;
      if (b_word.lim_en) begin
         if (off_ext > lim_pos) begin
            off_lim = lim_pos;
         end else if (off_ext < lim_neg) begin
            off_lim = lim_neg;
         end
      end
   end

   // servo centre plus offset, maximum tested first
   assign duty_raw = {off_lim[ERR_W-1], off_lim} + MID_C;

   always_comb begin
      if (duty_raw > MAX_C) begin
         duty_clip = MAX_C;
      end else if (duty_raw < MIN_C) begin
         duty_clip = MIN_C;
      end else begin
         duty_clip = duty_raw;
      end
   end

   // output register and held offset
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         held_ff    <= '0;
      end else begin
         if (b_ready) out_vld_ff <= b_valid;
         if (fire) held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         duty_ff   <= duty_clip[DUTY_W-1:0];
         offset_ff <= held_in;
      end
   end

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.servo_duty = duty_ff;
   assign rsp_ch.pd_offset  = offset_ff;

`include "gain_scheduled_pd_steering_core_assert.svh"

   `GSPD_ASSERT_NEXT(b_held_hold, !fire, $stable(held_ff), "held offset moved without a word")
   `GSPD_ASSERT_SAME(b_duty_range, out_vld_ff && (SERVO_MIN <= SERVO_MAX),
                     (duty_ff >= MIN_D) && (duty_ff <= MAX_D), "servo duty out of range")
   `GSPD_ASSERT_SAME(b_offset_match, out_vld_ff, offset_ff == held_ff,
                     "reported offset differs from held offset")

endmodule

@@ design/gain_scheduled_pd_steering_core.sv @@
// ----------------------------------------------------------------------------
// gain_scheduled_pd_steering_core
// gain scheduled pd steering: heading error to clamped servo duty
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one control tick per word: heading sum, target error,
//   area code, nav flag, lap and section counters. rsp_ch returns one word
//   per tick: clamped servo duty and the held pd offset.
//   csr_we/csr_index/csr_wdata write the gains and limits; write only
//   while no word is in flight.
// pipeline and throughput
//   an accepted word passes the input register, the multiplier register and
//   the output register before it is shown on rsp_ch. one word per cycle is
//   accepted while rsp_ch.ready is high; the 24x17 and 24x18 multipliers in
//   the middle stage set the clock.
// reset
//   synchronous, active high: pipeline emptied, error history and held
//   offset cleared, gains zero, both limits 600.
// stall
//   while rsp_ch.ready is low the stages keep filling; up to three words
//   are held and then req_ch.ready drops until the output word is taken.
// ----------------------------------------------------------------------------
module gain_scheduled_pd_steering_core #(
   parameter int SERVO_MIN      = 500,
   parameter int SERVO_MID      = 750,
   parameter int SERVO_MAX      = 1000,
   parameter int START_SECTIONS = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gspd_req_if.sink                             req_ch,
   gspd_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [gspd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gspd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import gspd_pkg::*;

   cfg_type     cfg_ff;
   stage_a_type a_word;
   logic        a_valid;
   logic        a_ready;
   stage_b_type b_word;
   logic        b_valid;
   logic        b_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p_straight   <= '0;
         cfg_ff.gain_d_straight   <= '0;
         cfg_ff.gain_p_round      <= '0;
         cfg_ff.gain_d_round      <= '0;
         cfg_ff.gain_p_transition <= '0;
         cfg_ff.gain_d_transition <= '0;
         cfg_ff.start_limit       <= LIMIT_RESET;
         cfg_ff.straight_limit    <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P_STRAIGHT:   cfg_ff.gain_p_straight   <= csr_wdata;
            CSR_GAIN_D_STRAIGHT:   cfg_ff.gain_d_straight   <= csr_wdata;
            CSR_GAIN_P_ROUND:      cfg_ff.gain_p_round      <= csr_wdata;
            CSR_GAIN_D_ROUND:      cfg_ff.gain_d_round      <= csr_wdata;
            CSR_GAIN_P_TRANSITION: cfg_ff.gain_p_transition <= csr_wdata;
            CSR_GAIN_D_TRANSITION: cfg_ff.gain_d_transition <= csr_wdata;
            CSR_START_LIMIT:       cfg_ff.start_limit       <= csr_wdata[LIM_W-1:0];
            CSR_STRAIGHT_LIMIT:    cfg_ff.straight_limit    <= csr_wdata[LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   gspd_front #(
      .START_SECTIONS (START_SECTIONS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .cfg     (cfg_ff),
      .a_word  (a_word),
      .a_valid (a_valid),
      .a_ready (a_ready)
   );

   gspd_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .a_word  (a_word),
      .a_valid (a_valid),
      .a_ready (a_ready),
      .b_word  (b_word),
      .b_valid (b_valid),
      .b_ready (b_ready)
   );

   gspd_back #(
      .SERVO_MIN (SERVO_MIN),
      .SERVO_MID (SERVO_MID),
      .SERVO_MAX (SERVO_MAX)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .b_word  (b_word),
      .b_valid (b_valid),
      .b_ready (b_ready),
      .rsp_ch  (rsp_ch)
   );

endmodule
